### rtl/core/cumulative_ack_sack_tracker_top_assert.svh
// ----------------------------------------------------------------------------
// tracker assertion macros
// shared concurrent assertion forms for the cumulative ack tracker
// ----------------------------------------------------------------------------
`ifndef CUMULATIVE_ACK_SACK_TRACKER_TOP_ASSERT_SVH
`define CUMULATIVE_ACK_SACK_TRACKER_TOP_ASSERT_SVH

// checked only while out of reset
`define CASACK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define CASACK_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/core/casack_pkg.sv
// ----------------------------------------------------------------------------
// casack_pkg
// shared types and constants of the cumulative ack / sack tracker
// ----------------------------------------------------------------------------
`default_nettype none

package casack_pkg;

    // window size default
    localparam int DEF_WINDOW_SEGS = 64;

    // register reset values
    localparam logic [15:0] RST_SEG_SIZE     = 16'd1460;
    localparam logic [7:0]  RST_HEADER_BYTES = 8'd40;
    localparam logic [31:0] RST_FLOW_BYTES   = 32'd0;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SEG_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEADER_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FLOW_BYTES   = 2'd2;

    // stream widths
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 96;
    localparam int OUT_TUSER_W = 3;

    // position marker operation of a cell
    typedef enum logic [1:0] {
        MAP_HOLD,
        MAP_ALL,
        MAP_SCAN,
        MAP_STEP
    } t_map_op;

    // received bit operation of a cell
    typedef enum logic [1:0] {
        BIT_HOLD,
        BIT_SET,
        BIT_SHIFT,
        BIT_CLEAR
    } t_bit_op;

    // command broadcast to every cell
    typedef struct packed {
        t_map_op map_op;
        t_bit_op bit_op;
    } t_cell_ctl;

    // status gathered from the chain
    typedef struct packed {
        logic hit;      // marked cell holds a received segment
        logic ahead;    // a received segment lies beyond the marked cell
        logic any;      // any received segment in the window
        logic bit0;     // segment at the cumulative ack received
        logic tok_end;  // marker sits on the last cell
    } t_chain_stat;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_ADVANCE,
        ST_SCAN,
        ST_BARE
    } t_state;

endpackage

`default_nettype wire

### rtl/core/casack_cell.sv
// ----------------------------------------------------------------------------
// casack_cell
// one window slot: received bit plus a thermometer marker bit
// ----------------------------------------------------------------------------
`default_nettype none

module casack_cell (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  casack_pkg::t_cell_ctl i_ctl,
    input  wire                   i_head,
    input  wire                   i_map_prev,
    input  wire                   i_bit_next,
    output logic                  o_map,
    output logic                  o_bit,
    output logic                  o_tok,
    output logic                  o_hit,
    output logic                  o_ahead
);

    logic r_map;
    logic r_bit;
    logic n_map;
    logic n_bit;

    // marker edge and local status
    assign o_map   = r_map;
    assign o_bit   = r_bit;
    assign o_tok   = r_map & ~i_map_prev;
    assign o_hit   = o_tok & r_bit;
    assign o_ahead = r_map & i_map_prev & r_bit;

    // marker next value
    always_comb begin
        unique case (i_ctl.map_op)
            casack_pkg::MAP_HOLD: n_map = r_map;
            casack_pkg::MAP_ALL:  n_map = 1'b1;
            casack_pkg::MAP_SCAN: n_map = ~i_head;
            casack_pkg::MAP_STEP: n_map = i_map_prev;
            default:              n_map = r_map;
        endcase
    end

    // received bit next value
    always_comb begin
        unique case (i_ctl.bit_op)
            casack_pkg::BIT_HOLD:  n_bit = r_bit;
            casack_pkg::BIT_SET:   n_bit = r_bit | o_tok;
            casack_pkg::BIT_SHIFT: n_bit = i_bit_next;
            casack_pkg::BIT_CLEAR: n_bit = 1'b0;
            default:               n_bit = r_bit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= 1'b0;
            r_bit <= 1'b0;
        end else begin
            r_map <= n_map;
            r_bit <= n_bit;
        end
    end

endmodule

`default_nettype wire

### rtl/core/casack_chain.sv
// ----------------------------------------------------------------------------
// casack_chain
// row of window cells, bit 0 at the cumulative ack
// ----------------------------------------------------------------------------
`default_nettype none

module casack_chain #(
    parameter int WINDOW_SEGS = casack_pkg::DEF_WINDOW_SEGS
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  casack_pkg::t_cell_ctl   i_ctl,
    output casack_pkg::t_chain_stat o_stat
);

    logic [WINDOW_SEGS-1:0] w_map;
    logic [WINDOW_SEGS-1:0] w_bit;
    logic [WINDOW_SEGS-1:0] w_tok;
    logic [WINDOW_SEGS-1:0] w_hit;
    logic [WINDOW_SEGS-1:0] w_ahead;
    logic [WINDOW_SEGS-1:0] w_map_prev;
    logic [WINDOW_SEGS-1:0] w_bit_next;

    // neighbor links, zero beyond both ends
    assign w_map_prev = {w_map[WINDOW_SEGS-2:0], 1'b0};
    assign w_bit_next = {1'b0, w_bit[WINDOW_SEGS-1:1]};

    for (genvar g = 0; g < WINDOW_SEGS; g++) begin : g_cell
        casack_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (i_ctl),
            .i_head     (g == 0),
            .i_map_prev (w_map_prev[g]),
            .i_bit_next (w_bit_next[g]),
            .o_map      (w_map[g]),
            .o_bit      (w_bit[g]),
            .o_tok      (w_tok[g]),
            .o_hit      (w_hit[g]),
            .o_ahead    (w_ahead[g])
        );
    end

    // status reduction
    assign o_stat.hit     = |w_hit;
    assign o_stat.ahead   = |w_ahead;
    assign o_stat.any     = |w_bit;
    assign o_stat.bit0    = w_bit[0];
    assign o_stat.tok_end = w_tok[WINDOW_SEGS-1];

endmodule

`default_nettype wire

### rtl/core/casack_ctrl.sv
// ----------------------------------------------------------------------------
// casack_ctrl
// sequencer: locate segment, advance ack, walk window for sack items
// ----------------------------------------------------------------------------
`default_nettype none

module casack_ctrl (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire  [15:0]                          i_seg_size,
    input  wire  [7:0]                           i_header_bytes,
    input  wire  [31:0]                          i_flow_bytes,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire  [casack_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [casack_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic [casack_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
    output logic                                 m_axis_tlast,
    output casack_pkg::t_cell_ctl                o_cell_ctl,
    input  casack_pkg::t_chain_stat              i_stat
);

    casack_pkg::t_state r_state;
    casack_pkg::t_state n_state;

    logic [31:0] r_cum_ack;
    logic [31:0] r_bytes;
    logic [31:0] r_rem;
    logic [31:0] r_acc;
    logic [15:0] r_pkt;
    logic        r_dup;
    logic        r_beyond;

    logic        r_out_valid;
    logic [31:0] r_out_ack;
    logic [31:0] r_out_sack;
    logic [31:0] r_out_total;
    logic        r_out_sack_valid;
    logic        r_out_dup;
    logic        r_out_beyond;
    logic        r_out_last;

    logic [15:0] w_seg;
    logic [31:0] w_seq;
    logic [15:0] w_pkt;
    logic [15:0] w_pay;
    logic        w_accept;
    logic        w_below;
    logic        w_out_free;
    logic        w_rem_zero;
    logic        w_rem_short;
    logic        w_clamp;
    logic        w_emit;
    logic        w_emit_sack;
    logic        w_emit_last;

    // input fields and arithmetic
    assign w_seg       = (i_seg_size == 16'd0) ? 16'd1 : i_seg_size;
    assign w_seq       = s_axis_tdata[31:0];
    assign w_pkt       = s_axis_tdata[47:32];
    assign w_pay       = (r_pkt > {8'd0, i_header_bytes}) ? r_pkt - {8'd0, i_header_bytes}
                                                          : 16'd0;
    assign s_axis_tready = (r_state == casack_pkg::ST_IDLE);
    assign w_accept    = s_axis_tvalid & s_axis_tready;
    assign w_below     = w_seq < r_cum_ack;
    assign w_out_free  = ~r_out_valid | m_axis_tready;
    assign w_rem_zero  = (r_rem == 32'd0);
    assign w_rem_short = r_rem < {16'd0, w_seg};
    assign w_clamp     = ({1'b0, r_cum_ack} + {17'd0, w_seg}) > {1'b0, i_flow_bytes};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            casack_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_below ? casack_pkg::ST_ADVANCE : casack_pkg::ST_SEARCH;
                end
            end
            casack_pkg::ST_SEARCH: begin
                if (w_rem_zero || w_rem_short || i_stat.tok_end) begin
                    n_state = casack_pkg::ST_ADVANCE;
                end
            end
            casack_pkg::ST_ADVANCE: begin
                if (!i_stat.bit0) begin
                    n_state = i_stat.any ? casack_pkg::ST_SCAN : casack_pkg::ST_BARE;
                end
            end
            casack_pkg::ST_SCAN: begin
                if (i_stat.hit && w_out_free && !i_stat.ahead) begin
                    n_state = casack_pkg::ST_IDLE;
                end
            end
            casack_pkg::ST_BARE: begin
                if (w_out_free) begin
                    n_state = casack_pkg::ST_IDLE;
                end
            end
            default: n_state = casack_pkg::ST_IDLE;
        endcase
    end

    // cell commands and result emission
    always_comb begin
        o_cell_ctl.map_op = casack_pkg::MAP_HOLD;
        o_cell_ctl.bit_op = casack_pkg::BIT_HOLD;
        w_emit            = 1'b0;
        w_emit_sack       = 1'b0;
        w_emit_last       = 1'b0;
        unique case (r_state)
            casack_pkg::ST_IDLE: begin
                if (w_accept && !w_below) begin
                    o_cell_ctl.map_op = casack_pkg::MAP_ALL;
                end
            end
            casack_pkg::ST_SEARCH: begin
                if (w_rem_zero) begin
                    if (!i_stat.hit) begin
                        o_cell_ctl.bit_op = casack_pkg::BIT_SET;
                    end
                end else if (!w_rem_short && !i_stat.tok_end) begin
                    o_cell_ctl.map_op = casack_pkg::MAP_STEP;
                end
            end
            casack_pkg::ST_ADVANCE: begin
                if (i_stat.bit0) begin
                    o_cell_ctl.bit_op = w_clamp ? casack_pkg::BIT_CLEAR : casack_pkg::BIT_SHIFT;
                end else begin
                    o_cell_ctl.map_op = casack_pkg::MAP_SCAN;
                end
            end
            casack_pkg::ST_SCAN: begin
                if (i_stat.hit) begin
                    if (w_out_free) begin
                        w_emit      = 1'b1;
                        w_emit_sack = 1'b1;
                        w_emit_last = ~i_stat.ahead;
                        if (i_stat.ahead) begin
                            o_cell_ctl.map_op = casack_pkg::MAP_STEP;
                        end
                    end
                end else begin
                    o_cell_ctl.map_op = casack_pkg::MAP_STEP;
                end
            end
            casack_pkg::ST_BARE: begin
                if (w_out_free) begin
                    w_emit      = 1'b1;
                    w_emit_last = 1'b1;
                end
            end
            default: begin
                o_cell_ctl.map_op = casack_pkg::MAP_HOLD;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= casack_pkg::ST_IDLE;
            r_cum_ack   <= 32'd0;
            r_bytes     <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == casack_pkg::ST_SEARCH && w_rem_zero && !i_stat.hit) begin
                r_bytes <= r_bytes + {16'd0, w_pay};
            end
            if (r_state == casack_pkg::ST_ADVANCE && i_stat.bit0) begin
                r_cum_ack <= w_clamp ? i_flow_bytes : r_cum_ack + {16'd0, w_seg};
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // per item working values and output item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dup    <= w_below;
            r_beyond <= 1'b0;
            r_rem    <= w_seq - r_cum_ack;
            r_pkt    <= w_pkt;
        end
        if (r_state == casack_pkg::ST_SEARCH) begin
            if (w_rem_zero) begin
                r_dup <= r_dup | i_stat.hit;
            end else if (w_rem_short || i_stat.tok_end) begin
                r_beyond <= 1'b1;
            end else begin
                r_rem <= r_rem - {16'd0, w_seg};
            end
        end
        // sack offset follows the marker: byte offset of the marked cell
        if (r_state == casack_pkg::ST_ADVANCE && !i_stat.bit0) begin
            r_acc <= r_cum_ack + {16'd0, w_seg};
        end else if (r_state == casack_pkg::ST_SCAN &&
                     o_cell_ctl.map_op == casack_pkg::MAP_STEP) begin
            r_acc <= r_acc + {16'd0, w_seg};
        end
        if (w_emit) begin
            r_out_ack        <= r_cum_ack;
            r_out_sack       <= w_emit_sack ? r_acc : 32'd0;
            r_out_total      <= r_bytes;
            r_out_sack_valid <= w_emit_sack;
            r_out_dup        <= r_dup;
            r_out_beyond     <= r_beyond;
            r_out_last       <= w_emit_last;
        end
    end

    // output item
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_total, r_out_sack, r_out_ack};
    assign m_axis_tuser  = {r_out_beyond, r_out_dup, r_out_sack_valid};
    assign m_axis_tlast  = r_out_last;

`include "cumulative_ack_sack_tracker_top_assert.svh"

    `CASACK_ASSERT_ALWAYS(a_out_clear_on_rst, !i_rst_n |=> !r_out_valid, "output valid after reset")
    `CASACK_ASSERT(a_scan_has_work, (r_state == casack_pkg::ST_SCAN) |-> (i_stat.hit || i_stat.ahead), "scan with no segment left")
    `CASACK_ASSERT(a_bare_empty, (r_state == casack_pkg::ST_BARE) |-> !i_stat.any, "bare ack with segments in window")
    `CASACK_ASSERT(a_last_ends_run, (w_emit && w_emit_last) |=> (r_state == casack_pkg::ST_IDLE), "run did not end on last item")

endmodule

`default_nettype wire

### rtl/core/cumulative_ack_sack_tracker_top.sv
// ----------------------------------------------------------------------------
// cumulative_ack_sack_tracker_top
// receiver side of one flow: cumulative ack with selective ack entries
// ----------------------------------------------------------------------------
// Takes one data packet item at a time (byte offset and size including
// header), records its segment in a window of WINDOW_SEGS cells starting at
// the cumulative ack, advances the ack over in-order segments (capped at
// flow_bytes) and then gives one result item per received segment beyond the
// first gap, or one bare ack item when there is none; tlast marks the final
// item of each run. After the accept, a position marker walks the cell chain
// to the segment's slot (skipped for an offset below the ack), the ack
// advances one segment at a time until a step finds the gap, and then the
// marker walks the cells while reporting (a bare ack needs no walk). The ack
// advance and the report walk share the same window; the marker steps one
// cell per cycle, and a stalled output holds the report walk. The next item
// is taken as soon as the last result of a run sits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cumulative_ack_sack_tracker_top #(
    parameter int WINDOW_SEGS = casack_pkg::DEF_WINDOW_SEGS
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // configuration writes
    input  wire                                  i_cfg_wr_en,
    input  wire  [casack_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [casack_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // packet items
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // seq_no[31:0], pkt_bytes[47:32]
    input  wire  [casack_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // result items
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // ack_seq[31:0], sack_seq[63:32], byte_total[95:64]
    output logic [casack_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // sack_valid[0], duplicate[1], beyond_window[2]
    output logic [casack_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
    output logic                                 m_axis_tlast
);

    logic [15:0] r_seg_size;
    logic [7:0]  r_header_bytes;
    logic [31:0] r_flow_bytes;

    casack_pkg::t_cell_ctl   w_cell_ctl;
    casack_pkg::t_chain_stat w_stat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_size     <= casack_pkg::RST_SEG_SIZE;
            r_header_bytes <= casack_pkg::RST_HEADER_BYTES;
            r_flow_bytes   <= casack_pkg::RST_FLOW_BYTES;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                casack_pkg::CFG_IDX_SEG_SIZE:     r_seg_size     <= i_cfg_wdata[15:0];
                casack_pkg::CFG_IDX_HEADER_BYTES: r_header_bytes <= i_cfg_wdata[7:0];
                casack_pkg::CFG_IDX_FLOW_BYTES:   r_flow_bytes   <= i_cfg_wdata[31:0];
                default: begin
                    r_flow_bytes <= r_flow_bytes;
                end
            endcase
        end
    end

    casack_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_seg_size     (r_seg_size),
        .i_header_bytes (r_header_bytes),
        .i_flow_bytes   (r_flow_bytes),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .o_cell_ctl     (w_cell_ctl),
        .i_stat         (w_stat)
    );

    casack_chain #(
        .WINDOW_SEGS (WINDOW_SEGS)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_cell_ctl),
        .o_stat  (w_stat)
    );

endmodule

`default_nettype wire
